FILE: sv/ggc_pkg.sv
`timescale 1ns / 1ps

package ggc_pkg;

    // Field widths fixed by the stream words.
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int ACT_W = 2;

    // Maximum number of vertices that fit the five-bit index and colour fields.
    localparam int FIELD_LIMIT = 32;

    // Input actions.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COLOR = 2'd2;

    // Lowest colour not present in the used set; the top colour if all below it are taken.
    function automatic logic [IDX_W-1:0] first_free(input logic [FIELD_LIMIT-1:0] used);
        logic [IDX_W-1:0] c;
        c = IDX_W'(FIELD_LIMIT - 1);
        for (int i = FIELD_LIMIT - 2; i >= 0; i--)
        begin
            if (!used[i])
            begin
                c = IDX_W'(i);
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/greedy_graph_coloring.sv
`timescale 1ns / 1ps

// Channel     Direction  Signals                     Word
// s_axis      in         tvalid tready tdata tuser   one command (clear, add edge, colour)
// m_axis      out        tvalid tready tdata tlast   one vertex colour
// cfg         in         wr_en wr_data               vertex_count register
//
// A clear is taken in the idle state; an edge reads its row, then writes the row back.
// Colouring vertex u uses the single read port of the colour memory, which is visited
// once per earlier vertex. Reset clears the per-row valid bits at once, so no clearing
// pass is needed. A stalled output holds the run until the word is taken.

module greedy_graph_coloring
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [4:0] first_vertex, [9:5] second_vertex, [15:10] zero
    input  logic [15:0]          s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [4:0] vertex_index, [9:5] vertex_color, [15:10] color_count
    output logic [15:0]          m_axis_tdata,
    // is_last
    output logic                 m_axis_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CAP = (MAX_VERTICES < FIELD_LIMIT) ? MAX_VERTICES : FIELD_LIMIT;
    localparam int CW  = $clog2(CAP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_ROW,
        S_SCAN,
        S_PICK,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        vcount_reg;
    logic [IDX_W-1:0]        u_reg;
    logic [IDX_W-1:0]        v_reg;
    logic [IDX_W-1:0]        pv_reg;
    logic                    pend_reg;
    logic [FIELD_LIMIT-1:0]  used_reg;
    logic [IDX_W-1:0]        top_reg;
    logic [IDX_W-1:0]        color_reg;
    logic [IDX_W-1:0]        hi_reg;
    logic [IDX_W-1:0]        lo_reg;
    logic                    out_valid_reg;
    logic [15:0]             out_data_reg;
    logic                    out_last_reg;

    // Adjacency rows: row hi holds a bit for each lower-numbered neighbour.
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_q;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    adj_qvalid_reg;
    logic                    adj_rd_en;
    logic [AW-1:0]           adj_rd_addr;
    logic                    adj_wr_en;
    logic [AW-1:0]           adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic [MAX_VERTICES-1:0] adj_row;

    // Colour memory, written once per vertex in each run.
    logic [IDX_W-1:0]        col_mem [CAP];
    logic [IDX_W-1:0]        col_q;
    logic [CW-1:0]           col_rd_addr;

    // Decoded command and vertex count in use.
    logic [IDX_W-1:0]        in_first;
    logic [IDX_W-1:0]        in_second;
    logic [IDX_W-1:0]        edge_hi;
    logic [IDX_W-1:0]        edge_lo;
    logic [CNT_W-1:0]        n_active;
    logic                    edge_ok;
    logic                    in_fire;
    logic [IDX_W-1:0]        pick_color;
    logic                    is_last;
    logic                    emit_fire;
    logic [AW+IDX_W-1:0]     ext_rd;
    logic [AW+IDX_W-1:0]     ext_wr;
    logic [AW+IDX_W-1:0]     ext_pv;

    assign in_first  = s_axis_tdata[IDX_W-1:0];
    assign in_second = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign edge_hi   = (in_first > in_second) ? in_first : in_second;
    assign edge_lo   = (in_first > in_second) ? in_second : in_first;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (vcount_reg > CNT_W'(CAP))
        begin
            n_active = CNT_W'(CAP);
        end
        else
        begin
            n_active = vcount_reg;
        end
    end

    // A self-loop never matters for colouring, so it is not stored.
    assign edge_ok = ({1'b0, edge_hi} < n_active) && (in_first != in_second);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Adjacency port control.
    assign adj_rd_en   = (in_fire && s_axis_tuser == ACT_EDGE && edge_ok) || (state_reg == S_ROW);
    assign ext_rd      = {{AW{1'b0}}, ((state_reg == S_ROW) ? u_reg : edge_hi)};
    assign adj_rd_addr = ext_rd[AW-1:0];
    assign adj_row     = adj_qvalid_reg ? adj_q : '0;
    assign adj_wr_en   = (state_reg == S_EDGE);
    assign ext_wr      = {{AW{1'b0}}, hi_reg};
    assign adj_wr_addr = ext_wr[AW-1:0];
    assign adj_wr_data = adj_row | (MAX_VERTICES'(1) << lo_reg);
    assign ext_pv      = {{AW{1'b0}}, pv_reg};

    always_ff @(posedge clk)
    begin
        if (adj_wr_en)
        begin
            adj_mem[adj_wr_addr] <= adj_wr_data;
        end
        if (adj_rd_en)
        begin
            adj_q <= adj_mem[adj_rd_addr];
        end
    end

    // Colour memory port control.
    assign col_rd_addr = v_reg[CW-1:0];
    assign pick_color  = (u_reg == '0) ? '0 : first_free(used_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PICK)
        begin
            col_mem[u_reg[CW-1:0]] <= pick_color;
        end
        col_q <= col_mem[col_rd_addr];
    end

    assign is_last = ({1'b0, u_reg} + CNT_W'(1) == n_active);

    // A new word is loaded when the output register is empty or being taken.
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    // Row valid bits: cleared by reset and by a clear command, set on write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            adj_qvalid_reg <= 1'b0;
        end
        else
        begin
            if (adj_rd_en)
            begin
                adj_qvalid_reg <= row_valid_reg[adj_rd_addr];
            end
            if (in_fire && s_axis_tuser == ACT_CLEAR)
            begin
                row_valid_reg <= '0;
            end
            else if (adj_wr_en)
            begin
                row_valid_reg[adj_wr_addr] <= 1'b1;
            end
        end
    end

    // Sequencer, configuration register and output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= CNT_W'(FIELD_LIMIT);
            u_reg         <= '0;
            v_reg         <= '0;
            pv_reg        <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            top_reg       <= '0;
            color_reg     <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == ACT_EDGE && edge_ok)
                        begin
                            hi_reg    <= edge_hi;
                            lo_reg    <= edge_lo;
                            state_reg <= S_EDGE;
                        end
                        else if (s_axis_tuser == ACT_COLOR)
                        begin
                            u_reg     <= '0;
                            top_reg   <= '0;
                            state_reg <= S_ROW;
                        end
                    end
                end

                S_EDGE:
                begin
                    state_reg <= S_IDLE;
                end

                S_ROW:
                begin
                    v_reg     <= '0;
                    pend_reg  <= 1'b0;
                    used_reg  <= '0;
                    state_reg <= S_SCAN;
                end

                // One colour read issued per earlier vertex; its data is folded in next cycle.
                S_SCAN:
                begin
                    if (pend_reg && adj_row[ext_pv[AW-1:0]])
                    begin
                        used_reg <= used_reg | (FIELD_LIMIT'(1) << col_q);
                    end
                    if (v_reg < u_reg)
                    begin
                        pv_reg   <= v_reg;
                        pend_reg <= 1'b1;
                        v_reg    <= v_reg + IDX_W'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_PICK;
                        end
                    end
                end

                S_PICK:
                begin
                    color_reg <= pick_color;
                    if (pick_color > top_reg)
                    begin
                        top_reg <= pick_color;
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_last_reg  <= is_last;
                        out_data_reg  <= {(is_last ? ({1'b0, top_reg} + CNT_W'(1)) : CNT_W'(0)),
                                          color_reg, u_reg};
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            u_reg     <= u_reg + IDX_W'(1);
                            state_reg <= S_ROW;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
